@@ rtl/marl_pkg.sv @@
// ----------------------------------------------------------------------------
// marl_pkg
// shared types and constants of the memory alert rate limiter
// ----------------------------------------------------------------------------
package marl_pkg;

	// alert codes as they appear on the result channel
	typedef enum logic [3:0] {
		ALERT_NONE      = 4'd0,
		ALERT_PS_CRIT   = 4'd1,
		ALERT_PS_WARN   = 4'd2,
		ALERT_PS_NOTICE = 4'd3,
		ALERT_SRAM      = 4'd4,
		ALERT_FRAG      = 4'd5,
		ALERT_SD        = 4'd6,
		ALERT_FLASH80   = 4'd7,
		ALERT_FLASH90   = 4'd8
	} alert_kind_t;

	localparam int unsigned NUM_KINDS = 8;
	localparam int unsigned SLOT_W    = 3;

	// slot of each kind in the per-kind state (kind minus one)
	localparam logic [SLOT_W-1:0] SLOT_PS_CRIT   = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_PS_WARN   = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_PS_NOTICE = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_SRAM      = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_FRAG      = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_SD        = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_FLASH80   = 3'd6;
	localparam logic [SLOT_W-1:0] SLOT_FLASH90   = 3'd7;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CRIT_BYTES        = 3'd0,
		CFG_WARN_BYTES        = 3'd1,
		CFG_NOTICE_BYTES      = 3'd2,
		CFG_BLOCK_HEAVY_BYTES = 3'd3,
		CFG_SRAM_LOW_BYTES    = 3'd4,
		CFG_GLOBAL_GAP_MS     = 3'd5,
		CFG_COOLDOWN_MEM_MS   = 3'd6,
		CFG_COOLDOWN_FRAG_MS  = 3'd7
	} cfg_index_t;

	// register reset values
	localparam logic [31:0] RST_CRIT_BYTES        = 32'd5242880;
	localparam logic [31:0] RST_WARN_BYTES        = 32'd6291456;
	localparam logic [31:0] RST_NOTICE_BYTES      = 32'd8388608;
	localparam logic [31:0] RST_BLOCK_HEAVY_BYTES = 32'd1048576;
	localparam logic [31:0] RST_SRAM_LOW_BYTES    = 32'd32768;
	localparam logic [31:0] RST_GLOBAL_GAP_MS     = 32'd10000;
	localparam logic [31:0] RST_COOLDOWN_MEM_MS   = 32'd60000;
	localparam logic [31:0] RST_COOLDOWN_FRAG_MS  = 32'd300000;

	// reduced ratio factors: 100*l < 36*f is 25*l < 9*f,
	// 100*u >= 90*t is 10*u >= 9*t, 100*u >= 80*t is 5*u >= 4*t
	localparam logic [4:0] FRAG_L_MUL = 5'd25;
	localparam logic [3:0] FRAG_F_MUL = 4'd9;
	localparam logic [3:0] F90_U_MUL  = 4'd10;
	localparam logic [3:0] F90_T_MUL  = 4'd9;
	localparam logic [2:0] F80_U_MUL  = 3'd5;
	localparam logic [2:0] F80_T_MUL  = 3'd4;

endpackage

@@ rtl/memory_alert_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// memory_alert_rate_limiter
// picks at most one memory alert per snapshot, with a global gap and
// per-kind cooldowns
// ----------------------------------------------------------------------------
// path: an accepted item goes to the input register, then to the result register on out_*
// throughput: one item per cycle while out_stall is low; the input and result registers
//   form a two-stage pipe; cooldown state is updated as an item enters the result register
// reset: arst_n clears all history (no alert issued yet) and restores register defaults
module memory_alert_rate_limiter
	import marl_pkg::*;
#(
	parameter logic [31:0] COOLDOWN_FLASH_MS = 32'd3600000,
	parameter logic [31:0] COOLDOWN_SD_MS    = 32'd600000
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	// snapshot channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        ps_present,
	input  logic [31:0] ps_free,
	input  logic [31:0] ps_largest,
	input  logic        int_present,
	input  logic [31:0] int_free,
	input  logic        flash_valid,
	input  logic [31:0] flash_used,
	input  logic [31:0] flash_total,
	input  logic        sd_error,
	input  logic [31:0] now_ms,

	// alert channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  alert
);

	// configuration registers
	logic [31:0] crit_bytes_q;
	logic [31:0] warn_bytes_q;
	logic [31:0] notice_bytes_q;
	logic [31:0] block_heavy_bytes_q;
	logic [31:0] sram_low_bytes_q;
	logic [31:0] global_gap_ms_q;
	logic [31:0] cooldown_mem_ms_q;
	logic [31:0] cooldown_frag_ms_q;

	// history
	logic [31:0]          last_issue_time_q [NUM_KINDS];
	logic [NUM_KINDS-1:0] issued_mask_q;
	logic [31:0]          last_any_time_q;
	logic                 any_issued_q;

	// input stage
	logic        valid_s1;
	logic        ps_present_s1;
	logic [31:0] ps_free_s1;
	logic [31:0] ps_largest_s1;
	logic        int_present_s1;
	logic [31:0] int_free_s1;
	logic        flash_valid_s1;
	logic [31:0] flash_used_s1;
	logic [31:0] flash_total_s1;
	logic        sd_error_s1;
	logic [31:0] now_ms_s1;

	// result stage
	logic        out_valid_q;
	alert_kind_t alert_q;

	// handshake
	logic in_take;
	logic s1_move;

	// decision logic
	logic [31:0]          cooldown [NUM_KINDS];
	logic [NUM_KINDS-1:0] ready;
	logic [NUM_KINDS-1:0] cand;
	logic [NUM_KINDS-1:0] fire;
	logic                 gap_block;
	logic                 ps_crit;
	logic                 ps_warn;
	logic                 ps_notice;
	logic                 frag_hi;
	logic                 flash_ok;
	logic                 flash90;
	logic                 flash80;
	logic [36:0]          frag_lhs;
	logic [35:0]          frag_rhs;
	logic [35:0]          f90_lhs;
	logic [35:0]          f90_rhs;
	logic [34:0]          f80_lhs;
	logic [34:0]          f80_rhs;
	alert_kind_t          pick;
	logic [SLOT_W-1:0]    pick_slot;
	logic [31:0]          gap_elapsed;

	// stage 1 advances when the result register is free or being emptied
	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign alert     = alert_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_bytes_q        <= RST_CRIT_BYTES;
			warn_bytes_q        <= RST_WARN_BYTES;
			notice_bytes_q      <= RST_NOTICE_BYTES;
			block_heavy_bytes_q <= RST_BLOCK_HEAVY_BYTES;
			sram_low_bytes_q    <= RST_SRAM_LOW_BYTES;
			global_gap_ms_q     <= RST_GLOBAL_GAP_MS;
			cooldown_mem_ms_q   <= RST_COOLDOWN_MEM_MS;
			cooldown_frag_ms_q  <= RST_COOLDOWN_FRAG_MS;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CRIT_BYTES:        crit_bytes_q        <= cfg_data;
				CFG_WARN_BYTES:        warn_bytes_q        <= cfg_data;
				CFG_NOTICE_BYTES:      notice_bytes_q      <= cfg_data;
				CFG_BLOCK_HEAVY_BYTES: block_heavy_bytes_q <= cfg_data;
				CFG_SRAM_LOW_BYTES:    sram_low_bytes_q    <= cfg_data;
				CFG_GLOBAL_GAP_MS:     global_gap_ms_q     <= cfg_data;
				CFG_COOLDOWN_MEM_MS:   cooldown_mem_ms_q   <= cfg_data;
				CFG_COOLDOWN_FRAG_MS:  cooldown_frag_ms_q  <= cfg_data;
			endcase
		end
	end

	// ----------------------------------------------------------- input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			ps_present_s1  <= ps_present;
			ps_free_s1     <= ps_free;
			ps_largest_s1  <= ps_largest;
			int_present_s1 <= int_present;
			int_free_s1    <= int_free;
			flash_valid_s1 <= flash_valid;
			flash_used_s1  <= flash_used;
			flash_total_s1 <= flash_total;
			sd_error_s1    <= sd_error;
			now_ms_s1      <= now_ms;
		end
	end

	// -------------------------------------------------------- candidate set
	// psram level gives at most one of critical, warning, notice
	assign ps_crit   = (ps_free_s1 < crit_bytes_q) || (ps_largest_s1 < block_heavy_bytes_q);
	assign ps_warn   = !ps_crit && (ps_free_s1 < warn_bytes_q);
	assign ps_notice = !ps_crit && !ps_warn && (ps_free_s1 < notice_bytes_q);

	// fragmentation above 64%: largest*100 < free*36, reduced by four
	assign frag_lhs = 37'(ps_largest_s1) * 37'(FRAG_L_MUL);
	assign frag_rhs = 36'(ps_free_s1) * 36'(FRAG_F_MUL);
	assign frag_hi  = frag_lhs < 37'(frag_rhs);

	// flash fill, used above the total simply lands in the 90% bucket
	assign f90_lhs  = 36'(flash_used_s1) * 36'(F90_U_MUL);
	assign f90_rhs  = 36'(flash_total_s1) * 36'(F90_T_MUL);
	assign f80_lhs  = 35'(flash_used_s1) * 35'(F80_U_MUL);
	assign f80_rhs  = 35'(flash_total_s1) * 35'(F80_T_MUL);
	assign flash_ok = flash_valid_s1 && (flash_total_s1 != 32'd0);
	assign flash90  = flash_ok && (f90_lhs >= f90_rhs);
	assign flash80  = flash_ok && !flash90 && (f80_lhs >= f80_rhs);

	always_comb begin
		cand                 = '0;
		cand[SLOT_PS_CRIT]   = ps_present_s1 && ps_crit;
		cand[SLOT_PS_WARN]   = ps_present_s1 && ps_warn;
		cand[SLOT_PS_NOTICE] = ps_present_s1 && ps_notice;
		cand[SLOT_SRAM]      = int_present_s1 && (int_free_s1 < sram_low_bytes_q);
		cand[SLOT_FRAG]      = ps_present_s1 && (ps_free_s1 >= warn_bytes_q) && frag_hi;
		cand[SLOT_SD]        = sd_error_s1;
		cand[SLOT_FLASH80]   = flash80;
		cand[SLOT_FLASH90]   = flash90;
	end

	// ------------------------------------------------------------- cooldowns
	always_comb begin
		cooldown[SLOT_PS_CRIT]   = cooldown_mem_ms_q;
		cooldown[SLOT_PS_WARN]   = cooldown_mem_ms_q;
		cooldown[SLOT_PS_NOTICE] = cooldown_mem_ms_q;
		cooldown[SLOT_SRAM]      = cooldown_mem_ms_q;
		cooldown[SLOT_FRAG]      = cooldown_frag_ms_q;
		cooldown[SLOT_SD]        = COOLDOWN_SD_MS;
		cooldown[SLOT_FLASH80]   = COOLDOWN_FLASH_MS;
		cooldown[SLOT_FLASH90]   = COOLDOWN_FLASH_MS;
	end

	// a kind is ready if never issued or its cooldown has run out (wrapping time)
	always_comb begin
		for (int k = 0; k < NUM_KINDS; k++) begin
			ready[k] = !issued_mask_q[k] ||
				((now_ms_s1 - last_issue_time_q[k]) >= cooldown[k]);
		end
	end

	assign gap_elapsed = now_ms_s1 - last_any_time_q;
	assign gap_block   = any_issued_q && (gap_elapsed < global_gap_ms_q);
	assign fire        = gap_block ? '0 : (cand & ready);

	// priority pick; psram kinds exclude each other, as do the two flash kinds
	always_comb begin
		pick      = ALERT_NONE;
		pick_slot = SLOT_PS_CRIT;
		priority if (fire[SLOT_PS_CRIT]) begin
			pick      = ALERT_PS_CRIT;
			pick_slot = SLOT_PS_CRIT;
		end else if (fire[SLOT_PS_WARN]) begin
			pick      = ALERT_PS_WARN;
			pick_slot = SLOT_PS_WARN;
		end else if (fire[SLOT_PS_NOTICE]) begin
			pick      = ALERT_PS_NOTICE;
			pick_slot = SLOT_PS_NOTICE;
		end else if (fire[SLOT_SRAM]) begin
			pick      = ALERT_SRAM;
			pick_slot = SLOT_SRAM;
		end else if (fire[SLOT_FRAG]) begin
			pick      = ALERT_FRAG;
			pick_slot = SLOT_FRAG;
		end else if (fire[SLOT_SD]) begin
			pick      = ALERT_SD;
			pick_slot = SLOT_SD;
		end else if (fire[SLOT_FLASH90]) begin
			pick      = ALERT_FLASH90;
			pick_slot = SLOT_FLASH90;
		end else if (fire[SLOT_FLASH80]) begin
			pick      = ALERT_FLASH80;
			pick_slot = SLOT_FLASH80;
		end else begin
			// nothing ready, or inside the global gap
			pick      = ALERT_NONE;
			pick_slot = SLOT_PS_CRIT;
		end
	end

	// --------------------------------------------------------------- history
	// updated as the item moves into the result register, so the next item
	// in stage 1 already sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KINDS; k++) begin
				last_issue_time_q[k] <= '0;
			end
			issued_mask_q   <= '0;
			last_any_time_q <= '0;
			any_issued_q    <= 1'b0;
		end else if (s1_move && (pick != ALERT_NONE)) begin
			last_issue_time_q[pick_slot] <= now_ms_s1;
			issued_mask_q[pick_slot]     <= 1'b1;
			last_any_time_q              <= now_ms_s1;
			any_issued_q                 <= 1'b1;
		end
	end

	// --------------------------------------------------------- result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			alert_q <= pick;
		end
	end

	// ------------------------------------------------------------ assertions
	// stall only while the input stage holds an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	// any_issued tracks the per-kind mask
	a_any_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		any_issued_q == (issued_mask_q != '0))
		else $error("any_issued out of step with issued mask");

	// an issued alert is recorded for its kind and shows up on the output
	a_issue_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && (pick != ALERT_NONE)) |=>
			(issued_mask_q[$past(pick_slot)] && (last_any_time_q == $past(now_ms_s1))
			 && out_valid_q && (alert_q == $past(pick))))
		else $error("issued alert not recorded");

	// within the global gap nothing is issued
	a_gap_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && gap_block) |=> (alert_q == ALERT_NONE))
		else $error("alert issued inside global gap");

endmodule
